[hdl/evg_pkg.sv]
// evg_pkg: shared constants, types and command/status structs
`timescale 1ns / 1ps
`default_nettype none
package evg_pkg;

  localparam int UNIFORM_BITS_DEF  = 32;
  localparam int OUT_FRAC_BITS_DEF = 16;
  localparam int OUT_INT_BITS      = 24;
  localparam int LOG_FRAC          = 48;
  localparam int ITER_W            = 6;
  localparam int EXP_W             = 6;
  localparam logic [63:0] LN2_Q64  = 64'hB17217F7D1CF79AC;

  localparam logic       REG_INV_RATE  = 1'b0;
  localparam logic       REG_METHOD    = 1'b1;
  localparam logic [31:0] INV_RATE_RST = 32'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_MUL,
    ST_SQU,
    ST_LNL,
    ST_LNV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_LN,
    MUL_SC
  } mul_kind_t;

  typedef struct packed {
    logic      accept;
    logic      norm_shift;
    logic      mul_en;
    logic [2:0] phase;
    mul_kind_t mul_sel;
    logic      sq_update;
    logic      load_l;
    logic      load_lnv;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic m_top;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[hdl/evg_if.sv]
// evg_if: stream interfaces for uniform words and output samples
`timescale 1ns / 1ps
`default_nettype none
interface uniform_if;
  logic        valid;
  logic        ready;
  logic [31:0] uniform_word;
  modport source (output valid, output uniform_word, input ready);
  modport sink (input valid, input uniform_word, output ready);
endinterface

interface sample_if #(parameter int WIDTH = 40);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

[hdl/evg_ctrl.sv]
// evg_ctrl: sequencing state machine for normalize, log squaring and scaling
`timescale 1ns / 1ps
`default_nettype none
module evg_ctrl
  import evg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t              state, state_next;
  mul_kind_t           kind, kind_next;
  logic [2:0]          phase, phase_next;
  logic [ITER_W-1:0]   iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kind  <= MUL_SQ;
      phase <= '0;
      iter  <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      phase <= phase_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next  = state;
    kind_next   = kind;
    phase_next  = (state == ST_MUL) ? phase + 3'd1 : 3'd0;
    iter_next   = iter;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.phase   = phase;
    cmd.mul_sel = kind;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.start) state_next = ST_NORM;
      end
      ST_NORM: begin
        if (status.m_top) begin
          state_next = ST_MUL;
          kind_next  = MUL_SQ;
        end else begin
          cmd.norm_shift = 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (phase == 3'd4) begin
          unique case (kind)
            MUL_SQ:  state_next = ST_SQU;
            MUL_LN:  state_next = ST_LNV;
            default: state_next = ST_OUT;
          endcase
        end
      end
      ST_SQU: begin
        cmd.sq_update = 1'b1;
        if (iter == ITER_W'(LOG_FRAC - 1)) begin
          iter_next  = '0;
          state_next = ST_LNL;
        end else begin
          iter_next  = iter + 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_LNL: begin
        cmd.load_l = 1'b1;
        state_next = ST_MUL;
        kind_next  = MUL_LN;
      end
      ST_LNV: begin
        cmd.load_lnv = 1'b1;
        state_next   = ST_MUL;
        kind_next    = MUL_SC;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hdl/evg_dp.sv]
// evg_dp: config registers, held word, log datapath and output register
`timescale 1ns / 1ps
`default_nettype none
module evg_dp
  import evg_pkg::*;
#(
  parameter int UNIFORM_BITS  = UNIFORM_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [31:0]                         cfg_data,
  input  wire logic [31:0]                         uniform_word,
  input  wire cmd_t                                cmd,
  output status_t                                  status,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [OUT_INT_BITS+OUT_FRAC_BITS-1:0]    sample
);

  localparam int UW      = (UNIFORM_BITS < 32) ? UNIFORM_BITS : 32;
  localparam int OUT_W   = OUT_INT_BITS + OUT_FRAC_BITS;
  localparam int SHIFT   = 64 - OUT_FRAC_BITS;
  localparam int SAT_LSB = SHIFT + OUT_W;
  localparam int NORM_SH = 64 - UNIFORM_BITS;

  logic [31:0]      inv_rate;
  logic             method;
  logic             have_first, have_next;
  logic [UW-1:0]    held_first, held_next;
  logic [UW-1:0]    u, operand;
  logic             start, dbl, dbl_r;
  logic [63:0]      m, opnd, a, b;
  logic [EXP_W-1:0] e;
  logic [LOG_FRAC-1:0] f;
  logic [31:0]      ah, bh;
  logic [63:0]      prod;
  logic [1:0]       psh;
  logic [127:0]     acc;

  assign u = uniform_word[UW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_rate <= INV_RATE_RST;
      method   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_RATE: inv_rate <= cfg_data;
        REG_METHOD:   method   <= cfg_data[0];
      endcase
    end
  end

  always_comb begin
    have_next = have_first;
    held_next = held_first;
    start     = 1'b0;
    operand   = u;
    dbl       = 1'b0;
    if (!method) begin
      have_next = 1'b0;
      held_next = '0;
      start     = (u != '0);
    end else if (!have_first) begin
      if (u != '0) begin
        held_next = u;
        have_next = 1'b1;
      end
    end else begin
      have_next = 1'b0;
      held_next = '0;
      if (u <= held_first) begin
        start   = 1'b1;
        operand = held_first;
        dbl     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_first <= 1'b0;
    end else if (cmd.accept) begin
      have_first <= have_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      held_first <= held_next;
      if (start) begin
        m     <= 64'(operand) << NORM_SH;
        e     <= '0;
        dbl_r <= dbl;
      end
    end else if (cmd.norm_shift) begin
      m <= m << 1;
      e <= e + 1'b1;
    end else if (cmd.sq_update) begin
      if (acc[127]) begin
        m <= acc[127:64];
        f <= {f[LOG_FRAC-2:0], 1'b1};
      end else begin
        m <= acc[126:63];
        f <= {f[LOG_FRAC-2:0], 1'b0};
      end
    end
  end

  // 64x64 product as four 32x32 partial products, one per cycle
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SQ: begin
        a = m;
        b = m;
      end
      MUL_LN: begin
        a = opnd;
        b = LN2_Q64;
      end
      default: begin
        a = opnd;
        b = 64'(inv_rate);
      end
    endcase
    ah = cmd.phase[1] ? a[63:32] : a[31:0];
    bh = cmd.phase[0] ? b[63:32] : b[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= ah * bh;
      psh  <= {1'b0, cmd.phase[1]} + {1'b0, cmd.phase[0]};
      if (cmd.phase == 3'd0) begin
        acc <= '0;
      end else begin
        acc <= acc + (128'(prod) << (32 * psh));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_l) begin
      opnd <= ((64'(e) + 64'd1) << LOG_FRAC) - 64'(f);
    end else if (cmd.load_lnv) begin
      opnd <= dbl_r ? {acc[126:64], 1'b0} : acc[127:64];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample <= (|acc[127:SAT_LSB]) ? '1 : acc[SAT_LSB-1:SHIFT];
    end
  end

  assign status.start    = start;
  assign status.m_top    = m[63];
  assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

[hdl/exponential_variate_generator.sv]
// exponential_variate_generator: exponential variates from uniform words
// An item that produces a sample holds the sequencer from its transfer until the next word can
// be taken: n being the leading zero count of the operand, it makes n normalize shifts (one
// per cycle), each 64x64 product runs on one shared 32x32 multiplier, and log2 needs 48
// squarings. Items that give no sample (zero words other than the second of a pair, a held
// first word, a rejected pair) leave the sequencer idle. Input is taken only while the
// sequencer is idle; a finished sample waits in the output register, and while it waits a new
// sample holds the sequencer, which stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module exponential_variate_generator
  import evg_pkg::*;
#(
  parameter int UNIFORM_BITS  = UNIFORM_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  uniform_if.sink          in_ch,
  sample_if.source         out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  evg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  evg_dp #(
    .UNIFORM_BITS  (UNIFORM_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .uniform_word (in_ch.uniform_word),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .sample       (out_ch.sample)
  );

  a_norm_needed: assert property (@(posedge clk) disable iff (rst)
    cmd.norm_shift |-> !status.m_top)
    else $error("normalize shift with leading one already in place");

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && !status.start |=> in_ch.ready)
    else $error("transfer without result left the block busy");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_ch.valid)
    else $error("output register not valid after load");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// tb: self-checking testbench for exponential_variate_generator
`timescale 1ns / 1ps
module tb;
  import evg_pkg::*;

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_NONE, ROW_VALUE} row_kind_t;
  typedef struct {
    row_kind_t   kind;
    logic        idx;
    logic [31:0] val;
    logic [39:0] fixed_sample;
  } row_t;

  localparam logic [39:0] SAMPLE_MAX = {40{1'b1}};
  localparam int DRAIN_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  uniform_if in_ch ();
  sample_if #(.WIDTH(40)) out_ch ();

  exponential_variate_generator dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] rate_q16;
  logic        rejection_mode;
  logic [31:0] held_u1;
  logic        u1_valid;

  logic [39:0] pending_samples[$];
  int errors = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 59;
  int samples_seen = 0;
  int hold_cycles = 0;
  bit hold_done = 0;
  bit all_sent = 0;

  function automatic logic [63:0] neg_ln_q48(logic [63:0] u);
    int lead;
    logic [63:0]  mant;
    logic [63:0]  frac_bits;
    logic [127:0] sq;
    logic [63:0]  log2_val;
    logic [127:0] prod;
    lead = 63;
    frac_bits = '0;
    while (lead > 0 && u[lead] == 1'b0) lead--;
    mant = u << (63 - lead);
    for (int i = 1; i <= LOG_FRAC; i++) begin
      sq = mant * mant;
      if (sq[127]) begin
        frac_bits[LOG_FRAC - i] = 1'b1;
        mant = sq[127:64];
      end else begin
        mant = sq[126:63];
      end
    end
    log2_val = (64'(32 - lead) << LOG_FRAC) - frac_bits;
    prod = log2_val * LN2_Q64;
    return prod[127:64];
  endfunction

  function automatic logic [39:0] scale_sample(logic [63:0] lnv, logic [31:0] rate);
    logic [127:0] prod;
    prod = lnv * {96'd0, rate};
    if (|prod[127:88]) return SAMPLE_MAX;
    return prod[87:48];
  endfunction

  task automatic predict_word(input logic [31:0] u, output bit has, output logic [39:0] s);
    has = 0;
    s = '0;
    if (!rejection_mode) begin
      u1_valid = 0;
      held_u1 = '0;
      if (u != 0) begin
        has = 1;
        s = scale_sample(neg_ln_q48({32'd0, u}), rate_q16);
      end
    end else if (!u1_valid) begin
      if (u != 0) begin
        held_u1 = u;
        u1_valid = 1;
      end
    end else begin
      u1_valid = 0;
      if (u <= held_u1) begin
        has = 1;
        s = scale_sample(neg_ln_q48({32'd0, held_u1}) << 1, rate_q16);
      end
      held_u1 = '0;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INV_RATE) rate_q16 = val;
    else rejection_mode = val[0];
  endtask

  task automatic send_word(input logic [31:0] w, input row_kind_t kind, input logic [39:0] fixed);
    bit has;
    logic [39:0] s;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.uniform_word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_word(w, has, s);
    if (kind == ROW_VALUE) pending_samples.push_back(fixed);
    else if (kind == ROW_PREDICT && has) pending_samples.push_back(s);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(15));
      3: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_rate();
    case ($urandom_range(5))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return 32'd65536;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // result side
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        samples_seen++;
        if (pending_samples.size() == 0) begin
          $display("%0t: unexpected sample transfer, actual %h", $time, out_ch.sample);
          errors++;
        end else begin
          if (out_ch.sample !== pending_samples[0]) begin
            $display("%0t: sample mismatch, expected %h, actual %h", $time,
                     pending_samples[0], out_ch.sample);
            errors++;
          end
          void'(pending_samples.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && samples_seen >= 150 && in_ch.valid && !in_ch.ready) begin
        hold_done <= 1;
        hold_cycles <= 3000;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #60ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    row_t rows[$];
    int wait_cycles;
    in_ch.valid = 1'b0;
    in_ch.uniform_word = '0;
    out_ch.ready = 1'b0;
    rate_q16 = INV_RATE_RST;
    rejection_mode = 0;
    held_u1 = '0;
    u1_valid = 0;

    rows = '{
      '{ROW_NONE,    1'b0, 32'd0,         40'd0},
      '{ROW_PREDICT, 1'b0, 32'd1,         40'd0},
      '{ROW_PREDICT, 1'b0, 32'hFFFF_FFFF, 40'd0},
      '{ROW_PREDICT, 1'b0, 32'h8000_0000, 40'd0},
      '{ROW_PREDICT, 1'b0, 32'h5555_5555, 40'd0},
      '{ROW_PREDICT, 1'b0, 32'hAAAA_AAAA, 40'd0},
      '{ROW_CFG,     REG_INV_RATE, 32'd0, 40'd0},
      '{ROW_VALUE,   1'b0, 32'h1234_5678, 40'd0},
      '{ROW_CFG,     REG_INV_RATE, 32'hFFFF_FFFF, 40'd0},
      '{ROW_PREDICT, 1'b0, 32'd1,         40'd0},
      '{ROW_PREDICT, 1'b0, 32'hFFFF_FFFF, 40'd0},
      '{ROW_CFG,     REG_METHOD, 32'd1,   40'd0},
      '{ROW_NONE,    1'b0, 32'd0,         40'd0},
      '{ROW_NONE,    1'b0, 32'h4000_0000, 40'd0},
      '{ROW_PREDICT, 1'b0, 32'd0,         40'd0},
      '{ROW_NONE,    1'b0, 32'd1,         40'd0},
      '{ROW_NONE,    1'b0, 32'd2,         40'd0},
      '{ROW_NONE,    1'b0, 32'hFFFF_FFFF, 40'd0},
      '{ROW_PREDICT, 1'b0, 32'hFFFF_FFFF, 40'd0},
      '{ROW_NONE,    1'b0, 32'h8000_0000, 40'd0},
      '{ROW_CFG,     REG_METHOD, 32'd0,   40'd0},
      '{ROW_PREDICT, 1'b0, 32'd3,         40'd0},
      '{ROW_CFG,     REG_INV_RATE, 32'd1, 40'd0},
      '{ROW_PREDICT, 1'b0, 32'h0000_8001, 40'd0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].val);
      else send_word(rows[i].val, rows[i].kind, rows[i].fixed_sample);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 12 : 0;
      for (int blk = 0; blk < 5; blk++) begin
        write_reg(REG_INV_RATE, random_rate());
        write_reg(REG_METHOD, 32'($urandom_range(1)));
        for (int n = 0; n < 106; n++) begin
          // rejection mode: mostly clean pairs with a nonzero first word
          if (rejection_mode && !u1_valid && $urandom_range(9) != 0) begin
            logic [31:0] first;
            first = random_word();
            if (first == 0) first = $urandom | 32'd1;
            send_word(first, ROW_PREDICT, '0);
            send_word($urandom_range(1) ? random_word() : $urandom_range(first), ROW_PREDICT, '0);
            n++;
          end else begin
            send_word(random_word(), ROW_PREDICT, '0);
          end
        end
      end
    end

    in_ch.valid <= 1'b0;
    all_sent = 1;
    wait_cycles = 0;
    while (pending_samples.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_samples.size() != 0) begin
      $display("%0t: %0d samples never arrived, next expected %h", $time,
               pending_samples.size(), pending_samples[0]);
      errors++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
